[rtl/mrlb_pkg.sv]
// Package of the minimum-raggedness line breaker.
// Holds the controller/datapath command and status structs and fixed field widths.
// No dependencies.
package mrlb_pkg;

    // Fixed widths of the configuration register and of the result fields.
    localparam int LW_W      = 10;
    localparam int OUT_IDX_W = 6;
    localparam int COST_W    = 36;
    localparam int CUBE_W    = 3 * LW_W;
    localparam logic [LW_W-1:0]   LW_RESET = 10'd80;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LONG = 2'd1;
    localparam logic [1:0] ST_MANY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // store the accepted word
        logic start;     // latch paragraph size, clear the load state
        logic err_out;   // load the error result
        logic row_init;  // begin row i of the dynamic program
        logic rd;        // read word k and suffix cost k+1
        logic acc;       // add word k to the line
        logic sq;        // square the slack
        logic cube;      // cube the slack
        logic cmp;       // compare candidate, advance k
        logic wb;        // write row i, step i down
        logic e_init;    // start emission at word 0
        logic e_rd;      // read break entry of the current line
        logic e_out;     // load one line result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_error;
        logic acc_over;
        logic acc_end;
        logic row_last;
        logic out_busy;
        logic out_ends;
    } sts_t;

endpackage

[rtl/mrlb_ctrl.sv]
// Controller of the minimum-raggedness line breaker.
// One-hot state machine sequencing loading, the backward DP and line emission.
// Depends on mrlb_pkg.
module mrlb_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           word_valid,
    input  logic           is_final_word,
    output logic           word_stall,
    input  mrlb_pkg::sts_t sts,
    output mrlb_pkg::cmd_t cmd
);
    import mrlb_pkg::*;

    typedef enum logic [11:0] {
        S_LOAD  = 12'b000000000001,
        S_CHECK = 12'b000000000010,
        S_ROW   = 12'b000000000100,
        S_RD    = 12'b000000001000,
        S_ACC   = 12'b000000010000,
        S_SQ    = 12'b000000100000,
        S_CUBE  = 12'b000001000000,
        S_CMP   = 12'b000010000000,
        S_WB    = 12'b000100000000,
        S_ERD   = 12'b001000000000,
        S_EOUT  = 12'b010000000000,
        S_EWAIT = 12'b100000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Words are taken only while loading.
    assign word_stall = (state_reg != S_LOAD);
    assign accept     = word_valid && (state_reg == S_LOAD);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD:
            begin
                cmd.load = accept;
                if (accept && is_final_word)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.start = 1'b1;
                if (sts.has_error)
                begin
                    cmd.err_out = 1'b1;
                    state_next  = S_EWAIT;
                end
                else
                    state_next = S_ROW;
            end
            S_ROW:
            begin
                cmd.row_init = 1'b1;
                state_next   = S_RD;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (sts.acc_over || sts.acc_end)
                    state_next = S_WB;
                else
                    state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = S_CUBE;
            end
            S_CUBE:
            begin
                cmd.cube   = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_RD;
            end
            S_WB:
            begin
                cmd.wb = 1'b1;
                if (sts.row_last)
                begin
                    cmd.e_init = 1'b1;
                    state_next = S_ERD;
                end
                else
                    state_next = S_ROW;
            end
            S_ERD:
            begin
                cmd.e_rd   = 1'b1;
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                cmd.e_out  = 1'b1;
                state_next = S_EWAIT;
            end
            S_EWAIT:
            begin
                if (!sts.out_busy)
                    state_next = sts.out_ends ? S_LOAD : S_ERD;
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/mrlb_dp.sv]
// Datapath of the minimum-raggedness line breaker.
// Word, suffix-cost and break memories, the cubic cost unit and the result register.
// Depends on mrlb_pkg.
module mrlb_dp #(
    parameter int MAX_WORDS = 64,
    parameter int LEN_BITS  = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mrlb_pkg::cmd_t                   cmd,
    output mrlb_pkg::sts_t                   sts,
    input  logic                             cfg_we,
    input  logic [mrlb_pkg::LW_W-1:0]        cfg_wdata,
    input  logic [LEN_BITS-1:0]              word_length,
    input  logic                             line_stall,
    output logic                             line_valid,
    output logic [mrlb_pkg::OUT_IDX_W-1:0]   first_word,
    output logic [mrlb_pkg::OUT_IDX_W-1:0]   last_word_index,
    output logic [mrlb_pkg::LW_W-1:0]        line_slack,
    output logic [mrlb_pkg::COST_W-1:0]      paragraph_cost,
    output logic                             ends_paragraph,
    output logic [1:0]                       status
);
    import mrlb_pkg::*;

    localparam int IDX_W  = $clog2(MAX_WORDS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int CW     = (LEN_BITS > LW_W) ? LEN_BITS : LW_W;
    localparam int USED_W = CW + 2;
    localparam int NODE_W = IDX_W + LW_W + 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_WORDS);

    // Memories.
    logic [LEN_BITS-1:0] wl_mem [MAX_WORDS];
    logic [COST_W-1:0]   sc_mem [MAX_WORDS];
    logic [NODE_W-1:0]   nd_mem [MAX_WORDS];
    logic [LEN_BITS-1:0] wl_rd;
    logic [COST_W-1:0]   sc_rd;
    logic [NODE_W-1:0]   nd_rd;

    // Control and DP registers.
    logic [LW_W-1:0]     lw_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [1:0]          err_reg;
    logic [LEN_BITS-1:0] maxlen_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [IDX_W-1:0]    i_reg;
    logic [IDX_W-1:0]    k_reg;
    logic [IDX_W-1:0]    e_idx_reg;
    logic [USED_W-1:0]   used_reg;
    logic [LW_W-1:0]     slack_reg;
    logic [2*LW_W-1:0]   sq_reg;
    logic [CUBE_W-1:0]   cube_reg;
    logic [COST_W-1:0]   best_reg;
    logic [IDX_W-1:0]    brk_reg;
    logic [LW_W-1:0]     bslack_reg;
    logic                fits_reg;
    logic                firstcand_reg;
    logic [COST_W-1:0]   cost_reg;
    logic                out_valid_reg;

    logic [IDX_W-1:0]    last_idx;
    logic [IDX_W-1:0]    sc_addr;
    logic [USED_W-1:0]   used_new;
    logic [USED_W-1:0]   lw_ext;
    logic                acc_over;
    logic                acc_end;
    logic [LW_W-1:0]     slack_new;
    logic [COST_W:0]     cand_sum;
    logic [COST_W-1:0]   cand;
    logic                long_now;
    logic                maxlen_long;
    logic [IDX_W-1:0]    nd_brk;
    logic [LW_W-1:0]     nd_slack;
    logic                nd_fits;

    // Line accumulation and the whole-suffix fit test.
    assign last_idx    = IDX_W'(n_reg - CNT_W'(1));
    assign sc_addr     = (k_reg == last_idx) ? k_reg : IDX_W'(k_reg + IDX_W'(1));
    assign lw_ext      = USED_W'(lw_reg);
    assign used_new    = used_reg + USED_W'(wl_rd)
                         + ((k_reg != i_reg) ? USED_W'(1) : USED_W'(0));
    assign acc_over    = (used_new > lw_ext);
    assign acc_end     = (k_reg == last_idx);
    assign slack_new   = LW_W'(lw_ext - used_new);
    assign long_now    = (CW'(word_length) > CW'(lw_reg));
    assign maxlen_long = (CW'(maxlen_reg) > CW'(lw_reg));

    // Candidate cost with saturation.
    assign cand_sum = {1'b0, sc_rd} + (COST_W+1)'(cube_reg);
    assign cand     = cand_sum[COST_W] ? COST_MAX : cand_sum[COST_W-1:0];

    assign {nd_brk, nd_slack, nd_fits} = nd_rd;

    assign sts.has_error = (err_reg != ST_OK) || maxlen_long;
    assign sts.acc_over  = acc_over;
    assign sts.acc_end   = acc_end;
    assign sts.row_last  = (i_reg == '0);
    assign sts.out_busy  = out_valid_reg;
    assign sts.out_ends  = ends_paragraph;

    assign line_valid = out_valid_reg;

    // Memory ports.
    always_ff @(posedge clk)
    begin
        if (cmd.load && (cnt_reg < CNT_FULL))
            wl_mem[cnt_reg[IDX_W-1:0]] <= word_length;
        if (cmd.wb)
        begin
            sc_mem[i_reg] <= best_reg;
            nd_mem[i_reg] <= {brk_reg, bslack_reg, fits_reg};
        end
        if (cmd.rd)
        begin
            wl_rd <= wl_mem[k_reg];
            sc_rd <= sc_mem[sc_addr];
        end
        if (cmd.e_rd)
            nd_rd <= nd_mem[e_idx_reg];
    end

    // Configuration register and load-phase state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg     <= LW_RESET;
            cnt_reg    <= '0;
            err_reg    <= ST_OK;
            maxlen_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                lw_reg <= cfg_wdata;
            if (cmd.start)
            begin
                cnt_reg    <= '0;
                err_reg    <= ST_OK;
                maxlen_reg <= '0;
            end
            else if (cmd.load)
            begin
                if (cnt_reg < CNT_FULL)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (word_length > maxlen_reg)
                        maxlen_reg <= word_length;
                    if (long_now && (err_reg == ST_OK))
                        err_reg <= ST_LONG;
                end
                else
                    err_reg <= ST_MANY;
            end
        end
    end

    // Dynamic program registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            n_reg <= cnt_reg;
            i_reg <= IDX_W'(cnt_reg - CNT_W'(1));
        end
        if (cmd.row_init)
        begin
            k_reg         <= i_reg;
            used_reg      <= '0;
            fits_reg      <= 1'b0;
            firstcand_reg <= 1'b1;
        end
        if (cmd.acc)
        begin
            used_reg  <= used_new;
            slack_reg <= slack_new;
            if (!acc_over && acc_end)
            begin
                best_reg   <= '0;
                brk_reg    <= k_reg;
                bslack_reg <= slack_new;
                fits_reg   <= 1'b1;
            end
        end
        if (cmd.sq)
            sq_reg <= slack_reg * slack_reg;
        if (cmd.cube)
            cube_reg <= sq_reg * slack_reg;
        if (cmd.cmp)
        begin
            if (firstcand_reg || (cand < best_reg))
            begin
                best_reg   <= cand;
                brk_reg    <= k_reg;
                bslack_reg <= slack_reg;
            end
            firstcand_reg <= 1'b0;
            k_reg         <= k_reg + IDX_W'(1);
        end
        if (cmd.wb)
        begin
            if (i_reg == '0)
                cost_reg <= best_reg;
            else
                i_reg <= i_reg - IDX_W'(1);
        end
        if (cmd.e_init)
            e_idx_reg <= '0;
        if (cmd.e_out)
            e_idx_reg <= nd_brk + IDX_W'(1);
    end

    // Result register: held until the transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.err_out || cmd.e_out)
            out_valid_reg <= 1'b1;
        else if (!line_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.err_out)
        begin
            first_word      <= '0;
            last_word_index <= '0;
            line_slack      <= '0;
            paragraph_cost  <= '0;
            ends_paragraph  <= 1'b1;
            status          <= (err_reg == ST_MANY) ? ST_MANY : ST_LONG;
        end
        else if (cmd.e_out)
        begin
            first_word      <= OUT_IDX_W'(e_idx_reg);
            last_word_index <= OUT_IDX_W'(nd_fits ? last_idx : nd_brk);
            line_slack      <= nd_slack;
            paragraph_cost  <= cost_reg;
            ends_paragraph  <= nd_fits;
            status          <= ST_OK;
        end
    end

endmodule

[rtl/min_raggedness_line_breaker.sv]
// A paragraph of n words loads at one word per cycle; a check state then follows.
// The backward DP runs each candidate line (at most n*n/2) through read, accumulate,
// square, cube and compare on one shared cubic cost unit with two registered multiplies;
// each row closes with a write-back. Emission reads each line's break entry, loads its
// result. One paragraph at a time; words stall during the check, DP and emission.
// Reset (rst_n, asynchronous, active low): line_width = 80, word count and error cleared.
module min_raggedness_line_breaker #(
    parameter int MAX_WORDS = 64,
    parameter int LEN_BITS  = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mrlb_pkg::LW_W-1:0]        cfg_wdata,
    input  logic                             word_valid,
    output logic                             word_stall,
    input  logic [LEN_BITS-1:0]              word_length,
    input  logic                             is_final_word,
    output logic                             line_valid,
    input  logic                             line_stall,
    output logic [mrlb_pkg::OUT_IDX_W-1:0]   first_word,
    output logic [mrlb_pkg::OUT_IDX_W-1:0]   last_word_index,
    output logic [mrlb_pkg::LW_W-1:0]        line_slack,
    output logic [mrlb_pkg::COST_W-1:0]      paragraph_cost,
    output logic                             ends_paragraph,
    output logic [1:0]                       status
);
    import mrlb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    mrlb_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .word_valid    (word_valid),
        .is_final_word (is_final_word),
        .word_stall    (word_stall),
        .sts           (sts),
        .cmd           (cmd)
    );

    // Storage and arithmetic.
    mrlb_dp #(
        .MAX_WORDS (MAX_WORDS),
        .LEN_BITS  (LEN_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .word_length     (word_length),
        .line_stall      (line_stall),
        .line_valid      (line_valid),
        .first_word      (first_word),
        .last_word_index (last_word_index),
        .line_slack      (line_slack),
        .paragraph_cost  (paragraph_cost),
        .ends_paragraph  (ends_paragraph),
        .status          (status)
    );

endmodule

[rtl/mrlb_checker.sv]
// Port-level checks of the minimum-raggedness line breaker.
// Checker module and its bind to the top level; depends on mrlb_pkg.
module mrlb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           word_stall,
    input logic                           line_valid,
    input logic                           line_stall,
    input logic [mrlb_pkg::OUT_IDX_W-1:0] first_word,
    input logic [mrlb_pkg::OUT_IDX_W-1:0] last_word_index,
    input logic                           ends_paragraph,
    input logic [1:0]                     status
);
    import mrlb_pkg::*;

    // No new word is taken while a line result is pending.
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        line_valid |-> word_stall)
        else $error("word accepted while a line result is pending");

    // An error result is always the last one of its paragraph.
    a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (line_valid && (status != ST_OK)) |-> ends_paragraph)
        else $error("error result without end of paragraph");

    // A line never ends before it starts.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (line_valid && (status == ST_OK)) |-> (first_word <= last_word_index))
        else $error("line ends before it starts");

    // A stalled result transaction holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (line_valid && line_stall) |=> (line_valid && $stable(first_word)
                                        && $stable(status)))
        else $error("stalled result changed");

endmodule

bind min_raggedness_line_breaker mrlb_checker u_mrlb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .word_stall      (word_stall),
    .line_valid      (line_valid),
    .line_stall      (line_stall),
    .first_word      (first_word),
    .last_word_index (last_word_index),
    .ends_paragraph  (ends_paragraph),
    .status          (status)
);
